@@ rtl/wta_pkg.sv @@
// Shared types, constants and the rounding correction table of the temperature averager.
package wta_pkg;

  // One reading in and one average out per beat
  typedef struct packed {
    logic signed [7:0] sample_temp;
    logic [31:0]       now_ticks;
  } wta_in_t;

  typedef struct packed {
    logic signed [7:0] average_temp;
    logic [3:0]        samples_used;
  } wta_out_t;

  localparam int unsigned TEMP_W       = 8;
  localparam int unsigned TICK_W       = 32;
  localparam int unsigned CNT_FIELD_W  = 4;
  localparam int unsigned ROUND_BIAS   = 1000;
  localparam int unsigned CORR_W       = 10;
  localparam logic [31:0] TIMEOUT_INIT = 32'd3000;
  localparam int          AVG_MAX      = 127;
  localparam int          AVG_MIN      = -128;

  // Truncated ROUND_BIAS / n for n = 1..10
  function automatic logic [CORR_W-1:0] bias_corr(input logic [CNT_FIELD_W-1:0] n);
    logic [CORR_W-1:0] c;
    unique case (n)
      4'd1:    c = 10'd1000;
      4'd2:    c = 10'd500;
      4'd3:    c = 10'd333;
      4'd4:    c = 10'd250;
      4'd5:    c = 10'd200;
      4'd6:    c = 10'd166;
      4'd7:    c = 10'd142;
      4'd8:    c = 10'd125;
      4'd9:    c = 10'd111;
      4'd10:   c = 10'd100;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

@@ rtl/wta_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module wta_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 10,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/wta_div.sv @@
// Iterative restoring divider, one quotient bit per cycle, unsigned operands.
module wta_div #(
  parameter int unsigned DIVIDEND_W = 13,
  parameter int unsigned DIVISOR_W  = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient
);

  localparam int unsigned CNT_W = $clog2(DIVIDEND_W + 1);

  logic [DIVIDEND_W-1:0] quo_r;
  logic [DIVISOR_W-1:0]  rem_r;
  logic [DIVISOR_W-1:0]  dvs_r;
  logic [CNT_W-1:0]      cnt_r;
  logic                  busy_r;
  logic                  done_r;

  logic [DIVISOR_W:0]    rem_sh;
  logic [DIVISOR_W:0]    rem_diff;
  logic                  ge;

  // one restoring step
  always_comb begin
    rem_sh   = {rem_r, quo_r[DIVIDEND_W-1]};
    ge       = (rem_sh >= {1'b0, dvs_r});
    rem_diff = rem_sh - {1'b0, dvs_r};
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DIVIDEND_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath: dividend shifts out as quotient bits shift in
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DIVIDEND_W-2:0], ge};
      rem_r <= ge ? rem_diff[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

@@ rtl/windowed_temperature_averager_top.sv @@
// Top level of the windowed temperature averager: ring history, running sum, rounding divide.
//
//  channel | ports                                 | direction | beat
//  --------+---------------------------------------+-----------+------------------------------
//  in      | in_valid, in_stall, in_data           | input     | one reading and its tick count
//  out     | out_valid, out_stall, out_data        | output    | rounded mean and count used
//  cfg     | cfg_wr_en, cfg_wr_data                | input     | timeout_ticks, written at once
//
// Each reading passes the states READ, PREP, DIV and FIN on its way to the registered result:
// the RAM read of the oldest entry issues at the accept edge, READ does the sum update and
// write-back, PREP starts the divider, DIV lets the divider find one quotient bit per cycle
// until its done flag is seen, and FIN rounds and loads the output register once it is free.
// Reset (rst_n, synchronous) empties the history, zeroes the last tick and loads
// a timeout of 3000; the history RAM itself is never cleared.
// in_stall is high while a reading is in work; the finished result sits in the output
// register and a new reading is accepted while it waits for out_stall to drop.
module windowed_temperature_averager_top #(
  parameter int unsigned WINDOW_LEN = 10
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  wta_pkg::wta_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output wta_pkg::wta_out_t out_data,
  input  logic              cfg_wr_en,
  input  logic [31:0]       cfg_wr_data
);

  import wta_pkg::*;

  localparam int unsigned PTR_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int unsigned CNT_W = $clog2(WINDOW_LEN + 1);
  localparam int unsigned SUM_W = $clog2(128 * WINDOW_LEN + 1) + 1;
  localparam int unsigned DIV_W = $clog2(2 * (128 * WINDOW_LEN + ROUND_BIAS) + 1);
  localparam int unsigned NUM_W = DIV_W + 1;
  localparam int unsigned AVG_W = NUM_W + 2;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_READ = 5'b00010,
    ST_PREP = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_FIN  = 5'b10000
  } state_t;

  state_t                   state_r, state_nxt;
  logic [TICK_W-1:0]        timeout_r;
  logic [TICK_W-1:0]        last_ticks_r;
  logic [CNT_W-1:0]         fill_r;
  logic [PTR_W-1:0]         wptr_r;
  logic signed [SUM_W-1:0]  sum_r;
  logic [TEMP_W-1:0]        reading_r;
  logic                     neg_r;
  logic [DIV_W-1:0]         mag;
  logic                     out_valid_r;
  wta_out_t                 out_data_r;

  logic                     accept;
  logic                     timed_out;
  logic [TICK_W-1:0]        delta;
  logic                     full;
  logic [TEMP_W-1:0]        rd_data;
  logic signed [SUM_W-1:0]  sum_nxt;
  logic signed [NUM_W-1:0]  biased;
  logic signed [NUM_W-1:0]  dbl;
  logic                     div_start;
  logic                     div_done;
  logic [DIV_W-1:0]         quo;
  logic [CNT_FIELD_W-1:0]   n_field;
  logic signed [NUM_W-1:0]  q_s;
  logic signed [NUM_W:0]    t_s;
  logic signed [NUM_W:0]    half;
  logic signed [AVG_W-1:0]  avg;
  logic signed [TEMP_W-1:0] avg_sat;
  logic                     out_free;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign full     = (fill_r == CNT_W'(WINDOW_LEN));
  assign n_field  = CNT_FIELD_W'(fill_r);

  // modular tick distance against the timeout
  assign delta     = in_data.now_ticks - last_ticks_r;
  assign timed_out = (delta > timeout_r);

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_INIT;
    end else if (cfg_wr_en) begin
      timeout_r <= cfg_wr_data;
    end
  end

  // history ring: oldest entry is read at wptr, newest written back there
  wta_ram #(
    .WIDTH (TEMP_W),
    .DEPTH (WINDOW_LEN)
  ) u_hist (
    .clk     (clk),
    .wr_en   (state_r == ST_READ),
    .wr_addr (wptr_r),
    .wr_data (reading_r),
    .rd_en   (accept),
    .rd_addr (wptr_r),
    .rd_data (rd_data)
  );

  // running sum: add newest, drop the evicted oldest once full
  always_comb begin
    sum_nxt = sum_r + SUM_W'(signed'(reading_r));
    if (full) begin
      sum_nxt = sum_nxt - SUM_W'(signed'(rd_data));
    end
  end

  // divider operand: |2*(sum+bias)| and its sign
  always_comb begin
    biased = NUM_W'(sum_r) + NUM_W'(ROUND_BIAS);
    dbl    = biased <<< 1;
    mag    = DIV_W'(dbl[NUM_W-1] ? -dbl : dbl);
  end

  // state sequencer
  always_comb begin
    state_nxt = state_r;
    div_start = 1'b0;
    unique case (state_r)
      ST_IDLE: if (accept)   state_nxt = ST_READ;
      ST_READ: state_nxt = ST_PREP;
      ST_PREP: begin
        div_start = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV:  if (div_done) state_nxt = ST_FIN;
      ST_FIN:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      last_ticks_r <= '0;
      fill_r       <= '0;
      sum_r        <= '0;
      wptr_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        last_ticks_r <= in_data.now_ticks;
        if (timed_out) begin
          fill_r <= '0;
          sum_r  <= '0;
        end
      end else if (state_r == ST_READ) begin
        sum_r <= sum_nxt;
        if (!full) begin
          fill_r <= fill_r + 1'b1;
        end
        wptr_r <= (wptr_r == PTR_W'(WINDOW_LEN - 1)) ? '0 : wptr_r + 1'b1;
      end
    end
  end

  // payload holding registers
  always_ff @(posedge clk) begin
    if (accept) begin
      reading_r <= in_data.sample_temp;
    end
    if (state_r == ST_PREP) begin
      neg_r <= dbl[NUM_W-1];
    end
  end

  wta_div #(
    .DIVIDEND_W (DIV_W),
    .DIVISOR_W  (CNT_FIELD_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (mag),
    .divisor  (n_field),
    .done     (div_done),
    .quotient (quo)
  );

  // (q + 1) / 2 truncated toward zero, minus bias / n, then saturate
  always_comb begin
    q_s  = neg_r ? -signed'({1'b0, quo}) : signed'({1'b0, quo});
    t_s  = (NUM_W + 1)'(q_s) + (NUM_W + 1)'(1);
    half = t_s[NUM_W] ? -((-t_s) >>> 1) : (t_s >>> 1);
    avg  = AVG_W'(half) - AVG_W'(signed'({1'b0, bias_corr(n_field)}));
    priority if (avg > AVG_W'(AVG_MAX)) begin
      avg_sat = TEMP_W'(AVG_MAX);
    end else if (avg < AVG_W'(AVG_MIN)) begin
      avg_sat = TEMP_W'(AVG_MIN);
    end else begin
      avg_sat = TEMP_W'(avg);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_FIN && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_FIN && out_free) begin
      out_data_r.average_temp <= avg_sat;
      out_data_r.samples_used <= n_field;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
